>>> rtl/rwsr_pkg.sv
// ----------------------------------------------------------------------------
// Row weighted sum reciprocal: shared package
// Sizes, field widths, item mode codes and the matrix address helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rwsr_pkg;

  // Largest square matrix the storage holds.
  localparam int unsigned MAX_SIZE = 64;

  // Fixed field widths of the item channels.
  localparam int IDX_W  = 6;
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;
  localparam int MAT_W  = 16;

  // Reset value of the size register.
  localparam int unsigned SIZE_RESET = 64;

  // Derived storage and arithmetic widths.
  localparam int CNT_W  = $clog2(MAX_SIZE + 1);
  localparam int WGT_AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int MAT_AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
  localparam int PROD_W = DATA_W + MAT_W;
  localparam int SUM_W  = PROD_W + $clog2(MAX_SIZE + 1);
  localparam int REM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(DATA_W);

  // Item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_MAT = 2'd0,
    MODE_WGT = 2'd1,
    MODE_TGT = 2'd2
  } mode_t;

  // Flat matrix address of a row and column.
  function automatic logic [MAT_AW-1:0] mat_addr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] flat;
    flat = r * MAX_SIZE + c;
    return flat[MAT_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rwsr_if.sv
// ----------------------------------------------------------------------------
// Row weighted sum reciprocal: channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

// Command channel: matrix writes, weight writes and row targets.
interface rwsr_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rwsr_pkg::MODE_W-1:0]  mode;
  logic [rwsr_pkg::IDX_W-1:0]   row;
  logic [rwsr_pkg::IDX_W-1:0]   col;
  logic [rwsr_pkg::DATA_W-1:0]  data;

  modport source(output valid, mode, row, col, data, input ready);
  modport sink(input valid, mode, row, col, data, output ready);
endinterface

// Result channel: one balancing factor per row target.
interface rwsr_res_if;
  logic                         valid;
  logic                         ready;
  logic [rwsr_pkg::IDX_W-1:0]   result_row;
  logic [rwsr_pkg::DATA_W-1:0]  factor;
  logic                         zero_sum;
  logic                         saturated;

  modport source(output valid, result_row, factor, zero_sum, saturated, input ready);
  modport sink(input valid, result_row, factor, zero_sum, saturated, output ready);
endinterface

// Configuration channel: write data of the size register.
interface rwsr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rwsr_pkg::SIZE_W-1:0]  data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/row_weighted_sum_reciprocal_top.sv
// ----------------------------------------------------------------------------
// Row weighted sum reciprocal: top level
// One balancing step of a trip-distribution model over a stored cost matrix.
// ----------------------------------------------------------------------------
// The block keeps a square matrix of 16-bit costs and a vector of unsigned
// Q16.16 weights in two on-chip memories, loaded one entry per command item
// (mode 0 for a matrix entry, mode 1 for a weight, mode 3 is ignored). A
// row target item (mode 2) walks the first n columns of its row, n being
// the size register capped at the storage size, reading one matrix entry
// and one weight per cycle from the memories and accumulating their
// products exactly. It then divides target * 2^32 by the sum with a
// one-bit-per-cycle restoring divider and returns the quotient as an
// unsigned Q16.16 factor, flagging a zero sum (factor zero) or a quotient
// that does not fit (factor all ones). A target's time is set by the memory
// walk and the 32 divider steps; a zero or saturated sum skips the divider.
// The result waits in an output register, so the next command item is taken
// while an earlier result has not yet been collected. The size register may
// be written only while no target is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module row_weighted_sum_reciprocal_top (
  input  wire logic   clk,
  input  wire logic   rst,
  rwsr_cmd_if.sink    cmd,
  rwsr_res_if.source  result,
  rwsr_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_CHECK,
    S_DIV,
    S_FIN
  } state_t;

  state_t                          state;
  logic [rwsr_pkg::SIZE_W-1:0]     size_in_use;

  // Target context.
  logic [rwsr_pkg::IDX_W-1:0]      row_q;
  logic [rwsr_pkg::DATA_W-1:0]     tgt;
  logic [rwsr_pkg::CNT_W-1:0]      n_q;
  logic [rwsr_pkg::CNT_W-1:0]      cnt;
  logic                            zero_q;
  logic                            sat_q;

  // Multiply and accumulate pipeline.
  logic                            rd_vld;
  logic                            prod_vld;
  logic [rwsr_pkg::PROD_W-1:0]     prod;
  logic [rwsr_pkg::SUM_W-1:0]      acc;

  // Divider.
  logic [rwsr_pkg::REM_W-1:0]      rem;
  logic [rwsr_pkg::DATA_W-1:0]     quo;
  logic [rwsr_pkg::STEP_W-1:0]     step;

  // Output register.
  logic                            out_valid;
  logic [rwsr_pkg::IDX_W-1:0]      out_row;
  logic [rwsr_pkg::DATA_W-1:0]     out_factor;
  logic                            out_zero;
  logic                            out_sat;

  // Memory ports.
  logic                            mat_we;
  logic [rwsr_pkg::MAT_AW-1:0]     mat_waddr;
  logic [rwsr_pkg::MAT_AW-1:0]     mat_raddr;
  logic [rwsr_pkg::MAT_W-1:0]      mat_rdata;
  logic                            wgt_we;
  logic [rwsr_pkg::WGT_AW-1:0]     wgt_waddr;
  logic [rwsr_pkg::WGT_AW-1:0]     wgt_raddr;
  logic [rwsr_pkg::DATA_W-1:0]     wgt_rdata;
  logic                            rd_en;

  // Decode and helpers.
  logic                            cmd_fire;
  logic                            row_ok;
  logic                            col_ok;
  logic [rwsr_pkg::CNT_W-1:0]      n_eff;
  logic [rwsr_pkg::CNT_W-1:0]      cnt_next;
  logic [rwsr_pkg::REM_W-1:0]      rem_sh;
  logic [rwsr_pkg::REM_W-1:0]      acc_ext;
  logic                            ge;
  logic                            out_load;

  localparam logic [rwsr_pkg::STEP_W-1:0] STEP_LAST = rwsr_pkg::STEP_W'(rwsr_pkg::DATA_W - 1);

  // Handshakes: commands only while idle, configuration always.
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Index checks and the effective size.
  assign row_ok = 32'(cmd.row) < rwsr_pkg::MAX_SIZE;
  assign col_ok = 32'(cmd.col) < rwsr_pkg::MAX_SIZE;
  assign n_eff  = (32'(size_in_use) > rwsr_pkg::MAX_SIZE) ?
                  rwsr_pkg::CNT_W'(rwsr_pkg::MAX_SIZE) : rwsr_pkg::CNT_W'(size_in_use);

  // Memory writes from command items.
  assign mat_we    = cmd_fire && (cmd.mode == rwsr_pkg::MODE_MAT) && row_ok && col_ok;
  assign mat_waddr = rwsr_pkg::mat_addr(32'(cmd.row), 32'(cmd.col));
  assign wgt_we    = cmd_fire && (cmd.mode == rwsr_pkg::MODE_WGT) && col_ok;
  assign wgt_waddr = rwsr_pkg::WGT_AW'(cmd.col);

  // Memory reads during the row walk.
  assign rd_en     = (state == S_SUM);
  assign mat_raddr = rwsr_pkg::mat_addr(32'(row_q), 32'(cnt));
  assign wgt_raddr = rwsr_pkg::WGT_AW'(cnt);
  assign cnt_next  = cnt + rwsr_pkg::CNT_W'(1);

  // One restoring division step.
  assign rem_sh  = {rem[rwsr_pkg::REM_W-2:0], 1'b0};
  assign acc_ext = {1'b0, acc};
  assign ge      = (rem_sh >= acc_ext);

  // The finished result enters the output register once that is free.
  assign out_load = (state == S_FIN) && (!out_valid || result.ready);

  rwsr_ram #(
    .WIDTH (rwsr_pkg::MAT_W),
    .DEPTH (rwsr_pkg::MAX_SIZE * rwsr_pkg::MAX_SIZE)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (cmd.data[rwsr_pkg::MAT_W-1:0]),
    .re    (rd_en),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  rwsr_ram #(
    .WIDTH (rwsr_pkg::DATA_W),
    .DEPTH (rwsr_pkg::MAX_SIZE)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (cmd.data),
    .re    (rd_en),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  // State machine, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      size_in_use <= rwsr_pkg::SIZE_W'(rwsr_pkg::SIZE_RESET);
      rd_vld      <= 1'b0;
      prod_vld    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        size_in_use <= cfg.data;
      end

      // Multiply and accumulate pipeline.
      rd_vld   <= rd_en;
      prod_vld <= rd_vld;
      if (rd_vld) begin
        prod <= rwsr_pkg::PROD_W'(wgt_rdata) * rwsr_pkg::PROD_W'(mat_rdata);
      end
      if (prod_vld) begin
        acc <= acc + rwsr_pkg::SUM_W'(prod);
      end

      // Output register fills from the finish state and drains when taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire && (cmd.mode == rwsr_pkg::MODE_TGT)) begin
            row_q <= cmd.row;
            tgt   <= cmd.data;
            n_q   <= n_eff;
            cnt   <= '0;
            acc   <= '0;
            if (row_ok && (n_eff != '0)) begin
              state <= S_SUM;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_SUM: begin
          cnt <= cnt_next;
          if (cnt_next == n_q) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld && !prod_vld) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // A quotient of 2^32 or more shows as a target not below the sum.
          if (acc == '0) begin
            zero_q <= 1'b1;
            sat_q  <= 1'b0;
            quo    <= '0;
            state  <= S_FIN;
          end else if (rwsr_pkg::SUM_W'(tgt) >= acc) begin
            zero_q <= 1'b0;
            sat_q  <= 1'b1;
            quo    <= '1;
            state  <= S_FIN;
          end else begin
            zero_q <= 1'b0;
            sat_q  <= 1'b0;
            rem    <= rwsr_pkg::REM_W'(tgt);
            quo    <= '0;
            step   <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? (rem_sh - acc_ext) : rem_sh;
          quo  <= {quo[rwsr_pkg::DATA_W-2:0], ge};
          step <= step + rwsr_pkg::STEP_W'(1);
          if (step == STEP_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_row    <= row_q;
            out_factor <= quo;
            out_zero   <= zero_q;
            out_sat    <= sat_q;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Result channel.
  assign result.valid      = out_valid;
  assign result.result_row = out_row;
  assign result.factor     = out_factor;
  assign result.zero_sum   = out_zero;
  assign result.saturated  = out_sat;

endmodule

`default_nettype wire

>>> rtl/rwsr_ram.sv
// ----------------------------------------------------------------------------
// Row weighted sum reciprocal: generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rwsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rwsr_checker.sv
// ----------------------------------------------------------------------------
// Row weighted sum reciprocal: port checker
// Concurrent assertions on the top level's ports, attached with a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rwsr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         cmd_valid,
  input wire logic                         cmd_ready,
  input wire logic [rwsr_pkg::MODE_W-1:0]  cmd_mode,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic [rwsr_pkg::DATA_W-1:0]  res_factor,
  input wire logic                         res_zero_sum,
  input wire logic                         res_saturated
);

  // A waiting result is not withdrawn.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item withdrawn before it was taken");

  // A zero sum and saturation exclude each other.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_zero_sum && res_saturated))
    else $error("zero sum and saturation flagged together");

  // A zero sum gives a zero factor.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_zero_sum |-> (res_factor == '0))
    else $error("zero sum with nonzero factor");

  // Saturation clamps the factor to all ones.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_saturated |-> (res_factor == '1))
    else $error("saturation without clamped factor");

  // A row target keeps the block busy for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_mode == rwsr_pkg::MODE_TGT) |=> !cmd_ready)
    else $error("command taken right after a row target");

endmodule

bind row_weighted_sum_reciprocal_top rwsr_checker u_rwsr_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_mode      (cmd.mode),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_factor    (result.factor),
  .res_zero_sum  (result.zero_sum),
  .res_saturated (result.saturated)
);

`default_nettype wire

>>> sim/tb_row_weighted_sum_reciprocal_top.sv
// ----------------------------------------------------------------------------
// Row weighted sum reciprocal: top-level testbench
// Loads cost matrix entries and weights, sends row targets under several
// matrix sizes and compares every balancing factor against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_row_weighted_sum_reciprocal_top;

  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_GOAL = 540;
  localparam int IDLE_TAIL = 12;
  localparam int REPORT_MAX = 10;
  localparam int unsigned SIZE_TOP = (1 << rwsr_pkg::SIZE_W) - 1;
  localparam logic [rwsr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One expected balancing factor.
  typedef struct packed {
    logic [rwsr_pkg::IDX_W-1:0]  row;
    logic [rwsr_pkg::DATA_W-1:0] factor;
    logic                        zero_sum;
    logic                        saturated;
  } factor_rec_t;

  logic clk = 1'b0;
  logic rst;

  rwsr_cmd_if cmd_ch();
  rwsr_res_if res_ch();
  rwsr_cfg_if cfg_ch();

  row_weighted_sum_reciprocal_top DUT (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Local copy of the block's storage and size register.
  logic [rwsr_pkg::MAT_W-1:0]  cost_mem   [0:rwsr_pkg::MAX_SIZE*rwsr_pkg::MAX_SIZE-1];
  logic [rwsr_pkg::DATA_W-1:0] weight_mem [0:rwsr_pkg::MAX_SIZE-1];
  bit                          cost_set   [0:rwsr_pkg::MAX_SIZE*rwsr_pkg::MAX_SIZE-1];
  bit                          weight_set [0:rwsr_pkg::MAX_SIZE-1];
  logic [rwsr_pkg::SIZE_W-1:0] size_reg = rwsr_pkg::SIZE_W'(rwsr_pkg::SIZE_RESET);

  factor_rec_t pending_factors[$];
  int unsigned hot_rows[$];
  int unsigned accepted_cmds = 0;
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Columns summed by a target: the size register capped at the storage size.
  function automatic int unsigned used_cols();
    return (32'(size_reg) > rwsr_pkg::MAX_SIZE) ? rwsr_pkg::MAX_SIZE : 32'(size_reg);
  endfunction

  // Random value of random magnitude, so that small and large values both occur.
  function automatic logic [rwsr_pkg::DATA_W-1:0] rand_mag(input int unsigned max_w);
    int unsigned w;
    logic [rwsr_pkg::DATA_W-1:0] v;
    w = $urandom_range(0, max_w);
    v = $urandom;
    if (w < rwsr_pkg::DATA_W) v = v & ((32'h1 << w) - 32'h1);
    return v;
  endfunction

  // Matrix entry word: random cost below, junk in the dropped upper bits.
  function automatic logic [rwsr_pkg::DATA_W-1:0] cost_word();
    logic [rwsr_pkg::DATA_W-1:0] t;
    logic [rwsr_pkg::DATA_W-1:0] low;
    t = $urandom;
    low = rand_mag(rwsr_pkg::MAT_W);
    t[rwsr_pkg::MAT_W-1:0] = low[rwsr_pkg::MAT_W-1:0];
    return t;
  endfunction

  // Update the local storage for one accepted item and queue the factor that
  // a row target is expected to produce.
  function automatic void apply_cmd(input logic [rwsr_pkg::MODE_W-1:0] m,
                                    input logic [rwsr_pkg::IDX_W-1:0] r,
                                    input logic [rwsr_pkg::IDX_W-1:0] c,
                                    input logic [rwsr_pkg::DATA_W-1:0] d);
    logic [63:0] row_sum;
    logic [63:0] quot;
    int unsigned j;
    int unsigned n;
    factor_rec_t rec;
    case (m)
      rwsr_pkg::MODE_MAT: begin
        cost_mem[rwsr_pkg::mat_addr(32'(r), 32'(c))] = d[rwsr_pkg::MAT_W-1:0];
        cost_set[rwsr_pkg::mat_addr(32'(r), 32'(c))] = 1'b1;
      end
      rwsr_pkg::MODE_WGT: begin
        weight_mem[c] = d;
        weight_set[c] = 1'b1;
      end
      rwsr_pkg::MODE_TGT: begin
        row_sum = '0;
        n = used_cols();
        for (j = 0; j < n; j++)
          row_sum += 64'(weight_mem[rwsr_pkg::WGT_AW'(j)]) *
                     64'(cost_mem[rwsr_pkg::mat_addr(32'(r), j)]);
        rec.row = r;
        rec.factor = '0;
        rec.zero_sum = 1'b0;
        rec.saturated = 1'b0;
        if (row_sum == 64'd0) begin
          rec.zero_sum = 1'b1;
        end else begin
          quot = {d, 32'h0} / row_sum;
          if (quot > 64'hFFFF_FFFF) begin
            rec.saturated = 1'b1;
            rec.factor = '1;
          end else begin
            rec.factor = quot[rwsr_pkg::DATA_W-1:0];
          end
        end
        pending_factors.push_back(rec);
      end
      default: ;
    endcase
  endfunction

  // Send one command item, after a random gap unless steady, and record it once accepted.
  task automatic send_cmd(input logic [rwsr_pkg::MODE_W-1:0] m,
                          input logic [rwsr_pkg::IDX_W-1:0] r,
                          input logic [rwsr_pkg::IDX_W-1:0] c,
                          input logic [rwsr_pkg::DATA_W-1:0] d);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.row <= r;
    cmd_ch.col <= c;
    cmd_ch.data <= d;
    do @(posedge clk); while (!cmd_ch.ready);
    apply_cmd(m, r, c, d);
    if (m != MODE_UNUSED) accepted_cmds++;
  endtask

  // Stop sending and wait until every factor is back and writes have settled.
  task automatic wait_idle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Write the size register while the block is idle.
  task automatic set_size(input logic [rwsr_pkg::SIZE_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    size_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Write any weight below n that was never written.
  task automatic fill_weights(input int unsigned n);
    int unsigned j;
    for (j = 0; j < n; j++)
      if (!weight_set[rwsr_pkg::WGT_AW'(j)])
        send_cmd(rwsr_pkg::MODE_WGT, rwsr_pkg::IDX_W'($urandom_range(0, rwsr_pkg::MAX_SIZE - 1)),
                 rwsr_pkg::IDX_W'(j), rand_mag(rwsr_pkg::DATA_W));
  endtask

  // Write any entry of row r below column n that was never written.
  task automatic fill_row(input int unsigned r, input int unsigned n);
    int unsigned j;
    for (j = 0; j < n; j++)
      if (!cost_set[rwsr_pkg::mat_addr(r, j)])
        send_cmd(rwsr_pkg::MODE_MAT, rwsr_pkg::IDX_W'(r), rwsr_pkg::IDX_W'(j), cost_word());
  endtask

  // Zero sum, saturation and a zero target on a two-column matrix.
  task automatic test_flags();
    set_size(rwsr_pkg::SIZE_W'(2));
    send_cmd(rwsr_pkg::MODE_WGT, 0, 0, 32'h0000_0001);
    send_cmd(rwsr_pkg::MODE_WGT, 5, 1, 32'h0000_0000);
    // Upper bits of a matrix entry are dropped, leaving a cost of one.
    send_cmd(rwsr_pkg::MODE_MAT, 0, 0, 32'hABCD_0001);
    send_cmd(rwsr_pkg::MODE_MAT, 0, 1, 32'h0000_FFFF);
    send_cmd(rwsr_pkg::MODE_TGT, 0, 0, 32'd5);
    send_cmd(rwsr_pkg::MODE_TGT, 0, 63, 32'd0);
    send_cmd(rwsr_pkg::MODE_MAT, 1, 0, 32'h0000_0000);
    send_cmd(rwsr_pkg::MODE_MAT, 1, 1, 32'hFFFF_1234);
    send_cmd(rwsr_pkg::MODE_TGT, 1, 0, 32'hFFFF_FFFF);
  endtask

  // All-ones fields, large targets, the last row and the ignored mode.
  task automatic test_field_extremes();
    send_cmd(rwsr_pkg::MODE_WGT, 63, 0, 32'hFFFF_FFFF);
    send_cmd(rwsr_pkg::MODE_WGT, 0, 1, 32'hFFFF_FFFF);
    send_cmd(rwsr_pkg::MODE_MAT, 63, 0, 32'hFFFF_FFFF);
    send_cmd(rwsr_pkg::MODE_MAT, 63, 1, 32'hFFFF_FFFF);
    send_cmd(rwsr_pkg::MODE_TGT, 63, 63, 32'hFFFF_FFFF);
    send_cmd(rwsr_pkg::MODE_TGT, 63, 0, 32'h8000_0000);
    send_cmd(MODE_UNUSED, 63, 63, 32'hFFFF_FFFF);
    send_cmd(rwsr_pkg::MODE_TGT, 0, 0, 32'h0001_0000);
  endtask

  // Empty sum at size zero and rows beyond the size in use at size one.
  task automatic test_size_edges();
    set_size(rwsr_pkg::SIZE_W'(0));
    send_cmd(rwsr_pkg::MODE_TGT, 0, 0, 32'd123);
    set_size(rwsr_pkg::SIZE_W'(1));
    send_cmd(rwsr_pkg::MODE_TGT, 63, 0, 32'h7FFF_FFFF);
    send_cmd(rwsr_pkg::MODE_TGT, 1, 0, 32'd7);
  endtask

  // Phases of random traffic, each under its own size. Each target is first
  // given any writes still needed to make its row and weights defined.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned step;
    int unsigned steps;
    int unsigned n;
    int unsigned sz;
    int unsigned pick;
    int unsigned r;
    int unsigned c;
    int unsigned hot_span;
    phase = 0;
    while (accepted_cmds < ITEM_GOAL) begin
      if (phase == 0) begin
        sz = rwsr_pkg::MAX_SIZE;
      end else if (phase == 1) begin
        sz = SIZE_TOP;
      end else begin
        pick = $urandom_range(0, 15);
        if (pick == 0) sz = 0;
        else if (pick == 1) sz = $urandom_range(rwsr_pkg::MAX_SIZE + 1, SIZE_TOP);
        else if (pick == 2) sz = $urandom_range(17, rwsr_pkg::MAX_SIZE);
        else if (pick < 6) sz = $urandom_range(9, 16);
        else sz = $urandom_range(1, 8);
      end
      set_size(sz[rwsr_pkg::SIZE_W-1:0]);
      n = used_cols();
      steady = (phase % 4 == 3);
      steps = (n > 16) ? 16 : 40;
      for (step = 0; step < steps && accepted_cmds < ITEM_GOAL; step++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          // Wide rows are expensive to fill, so large sizes stay on few rows.
          if (hot_rows.size() == 0 || $urandom_range(0, (n > 16) ? 19 : 3) == 0) begin
            r = $urandom_range(0, rwsr_pkg::MAX_SIZE - 1);
            hot_rows.push_back(r);
          end else begin
            hot_span = (n > 16 && hot_rows.size() > 2) ? 2 : hot_rows.size();
            r = hot_rows[$urandom_range(0, hot_span - 1)];
          end
          fill_weights(n);
          fill_row(r, n);
          send_cmd(rwsr_pkg::MODE_TGT, rwsr_pkg::IDX_W'(r),
                   rwsr_pkg::IDX_W'($urandom_range(0, rwsr_pkg::MAX_SIZE - 1)),
                   rand_mag(rwsr_pkg::DATA_W));
        end else if (pick < 15) begin
          if (n > 0 && $urandom_range(0, 1) == 1) c = $urandom_range(0, n - 1);
          else c = $urandom_range(0, rwsr_pkg::MAX_SIZE - 1);
          send_cmd(rwsr_pkg::MODE_WGT,
                   rwsr_pkg::IDX_W'($urandom_range(0, rwsr_pkg::MAX_SIZE - 1)),
                   rwsr_pkg::IDX_W'(c), rand_mag(rwsr_pkg::DATA_W));
        end else if (pick < 19) begin
          if (n > 0 && hot_rows.size() != 0 && $urandom_range(0, 1) == 1) begin
            r = hot_rows[$urandom_range(0, hot_rows.size() - 1)];
            c = $urandom_range(0, n - 1);
          end else begin
            r = $urandom_range(0, rwsr_pkg::MAX_SIZE - 1);
            c = $urandom_range(0, rwsr_pkg::MAX_SIZE - 1);
          end
          send_cmd(rwsr_pkg::MODE_MAT, rwsr_pkg::IDX_W'(r), rwsr_pkg::IDX_W'(c), cost_word());
        end else begin
          send_cmd(MODE_UNUSED, rwsr_pkg::IDX_W'($urandom_range(0, rwsr_pkg::MAX_SIZE - 1)),
                   rwsr_pkg::IDX_W'($urandom_range(0, rwsr_pkg::MAX_SIZE - 1)), $urandom);
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, and each accepted factor checked in order.
  initial begin : factor_checker
    int unsigned stall;
    factor_rec_t want;
    stall = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        if (pending_factors.size() == 0) begin
          bad_results++;
          if (bad_results <= REPORT_MAX)
            $display("unexpected result: row %0d factor %h zero_sum %b saturated %b",
                     res_ch.result_row, res_ch.factor, res_ch.zero_sum, res_ch.saturated);
        end else begin
          want = pending_factors.pop_front();
          if (res_ch.result_row !== want.row || res_ch.factor !== want.factor ||
              res_ch.zero_sum !== want.zero_sum || res_ch.saturated !== want.saturated) begin
            bad_results++;
            if (bad_results <= REPORT_MAX) begin
              $write("mismatch: expected row %0d factor %h zero_sum %b saturated %b, ",
                     want.row, want.factor, want.zero_sum, want.saturated);
              $display("got row %0d factor %h zero_sum %b saturated %b",
                       res_ch.result_row, res_ch.factor, res_ch.zero_sum, res_ch.saturated);
            end
          end
        end
        stall = steady ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("row_weighted_sum_reciprocal_top test failed");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= '0;
    cmd_ch.row <= '0;
    cmd_ch.col <= '0;
    cmd_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_flags();
    test_field_extremes();
    test_size_edges();
    test_random_traffic();

    wait_idle();
    if (bad_results == 0) begin
      $display("row_weighted_sum_reciprocal_top test passed");
    end else begin
      $display("row_weighted_sum_reciprocal_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> row_weighted_sum_reciprocal_top.f
rtl/rwsr_pkg.sv
rtl/rwsr_if.sv
rtl/rwsr_ram.sv
rtl/row_weighted_sum_reciprocal_top.sv
rtl/rwsr_checker.sv
sim/tb_row_weighted_sum_reciprocal_top.sv
